FILE: hw/rtl/kmd_pkg.sv
// Shared types and constants for the key matrix debounce block.
package kmd_pkg;

   localparam int COLUMN_COUNT = 8;
   localparam int SAMPLE_W     = 8;
   localparam int ROW_W        = 3;
   localparam int COL_W        = 3;

   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } kmd_state_type;

   // Hand-over of one row update to the event serialiser
   typedef struct packed {
      logic                load;
      logic [ROW_W-1:0]    row;
      logic [SAMPLE_W-1:0] changed;
      logic [SAMPLE_W-1:0] level;
   } kmd_load_type;

endpackage

FILE: hw/rtl/kmd_row_mem.sv
// Row state memory: history and debounced level per row, registered read.
module kmd_row_mem
   import kmd_pkg::*;
#(
   parameter int ROW_COUNT = 8,
   parameter int ADDR_W    = 3,
   parameter int DATA_W    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0]    mem_ff [ROW_COUNT];
   logic [ROW_COUNT-1:0] valid_ff;
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // a row never written reads as its reset value
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/kmd_event_out.sv
// Event serialiser: one changed key per transaction, lowest column first.
module kmd_event_out
   import kmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  kmd_load_type     load,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ROW_W-1:0] rsp_event_row,
   output logic [COL_W-1:0] rsp_event_column,
   output logic             rsp_event_kind,
   output logic             rsp_last_event
);

   logic [SAMPLE_W-1:0] mask_ff, mask_in;
   logic [SAMPLE_W-1:0] level_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                rsp_valid_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic                rsp_kind_ff;
   logic                rsp_last_ff;

   logic                take;
   logic [COL_W-1:0]    pick_col;
   logic [SAMPLE_W-1:0] pick_bit;

   always_comb begin
      pick_col = '0;
      pick_bit = '0;
      for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            pick_col = COL_W'(c);
            pick_bit = SAMPLE_W'(1) << c;
         end
      end
   end

   assign take    = !rsp_valid_ff || !rsp_stall;
   assign mask_in = mask_ff & ~pick_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load.load) begin
         mask_ff <= load.changed;
         if (take) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (take) begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= mask_ff != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         level_ff <= load.level;
         row_ff   <= load.row;
      end
      if (take && !load.load && mask_ff != '0) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= pick_col;
         rsp_kind_ff <= level_ff[pick_col] ? KIND_PRESS : KIND_RELEASE;
         rsp_last_ff <= mask_in == '0;
      end
   end

   assign busy             = mask_ff != '0;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_row    = rsp_row_ff;
   assign rsp_event_column = rsp_col_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_last_event   = rsp_last_ff;

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      load.load |-> mask_ff == '0)
      else $error("row loaded while events still pending");

   a_more_after_non_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> mask_ff != '0)
      else $error("non-final event with nothing left to send");

endmodule

FILE: hw/rtl/key_matrix_debounce_events.sv
// Key matrix debouncer: one scanned row in, press and release events out.
// req_ carries one row scan (row index, 8 raw column levels); rsp_ carries
// one event per key whose debounced level changed, ascending by column, with
// rsp_last_event set on the final one. A scan that changes nothing gives no
// transaction; a row index at or above ROW_COUNT is taken and dropped.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// Each row's history and debounced level sit in one memory entry. A scan's
// entry is read when it is taken, arrives in the next cycle and is written back
// with the new history and level in that same cycle, then the events leave one
// a cycle while the receiver does not stall. A scan that changes nothing lets
// the next scan in once its row update is done; one with events, once its last
// event has entered the output register. The first event passes the memory read
// register, then the serialiser's mask and output registers. The output register
// lets the next scan be taken while the final event still waits. When the receiver
// stalls, that event holds and req_stall stays high until no event is left queued.
// Reset empties the event queue and marks every row as cleared, so history
// and levels start at zero with no clearing pass.
module key_matrix_debounce_events
   import kmd_pkg::*;
#(
   parameter int ROW_COUNT     = 8,
   parameter int HISTORY_DEPTH = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ROW_W-1:0]    req_row_index,
   input  logic [SAMPLE_W-1:0] req_column_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ROW_W-1:0]    rsp_event_row,
   output logic [COL_W-1:0]    rsp_event_column,
   output logic                rsp_event_kind,
   output logic                rsp_last_event
);

   localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int HIST_W = HISTORY_DEPTH * SAMPLE_W;
   localparam int DATA_W = HIST_W + SAMPLE_W;

   kmd_state_type       state_ff, state_in;
   logic [ROW_W-1:0]    row_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   logic                accept;
   logic                row_ok;
   logic                rd_en;
   logic                wr_en;
   logic [DATA_W-1:0]   rd_data;
   logic [DATA_W-1:0]   wr_data;
   logic [HIST_W-1:0]   hist_new;
   logic [SAMPLE_W-1:0] level_old, level_new, ones, zeros, changed;
   logic                evt_busy;
   kmd_load_type        evt_load;

   assign accept = req_valid && !req_stall;
   assign row_ok = int'(req_row_index) < ROW_COUNT;

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff    <= req_row_index;
         sample_ff <= req_column_sample;
      end
   end

   // newest sample in the low byte, oldest one falls off the top
   always_comb begin
      hist_new  = {rd_data[HIST_W-SAMPLE_W-1:0], sample_ff};
      level_old = rd_data[DATA_W-1:HIST_W];
      ones      = '1;
      zeros     = '1;
      for (int d = 0; d < HISTORY_DEPTH; d++) begin
         ones  = ones & hist_new[d*SAMPLE_W +: SAMPLE_W];
         zeros = zeros & ~hist_new[d*SAMPLE_W +: SAMPLE_W];
      end
      level_new = (level_old | ones) & ~zeros;
      changed   = level_old ^ level_new;
      wr_data   = {level_new, hist_new};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && row_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (changed != '0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!evt_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      evt_load  = '{load: 1'b0, row: row_ff, changed: changed, level: level_new};
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            rd_en     = req_valid && row_ok;
         end
         ST_READ: begin
            wr_en         = 1'b1;
            evt_load.load = changed != '0;
         end
         ST_EMIT: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   kmd_row_mem #(
      .ROW_COUNT(ROW_COUNT),
      .ADDR_W   (ADDR_W),
      .DATA_W   (DATA_W)
   ) u_row_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_addr(ADDR_W'(req_row_index)),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(ADDR_W'(row_ff)),
      .wr_data(wr_data)
   );

   kmd_event_out u_event_out (
      .clock           (clock),
      .reset           (reset),
      .load            (evt_load),
      .busy            (evt_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_row   (rsp_event_row),
      .rsp_event_column(rsp_event_column),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_last_event  (rsp_last_event)
   );

   a_read_then_update: assert property (@(posedge clock) disable iff (reset)
      (accept && row_ok) |=> state_ff == ST_READ)
      else $error("accepted scan did not proceed to the row update");

   a_single_writeback: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> !wr_en)
      else $error("row written back twice for one scan");

endmodule

FILE: bench/tb_key_matrix_debounce_events.sv
// Testbench for the key matrix debouncer: directed and random row scans, checked against a predictor.
`timescale 1ns / 1ps

module tb_key_matrix_debounce_events
   import kmd_pkg::*;
();

   localparam int ROWS        = 8;
   localparam int DEPTH       = 3;
   localparam int N_DIRECTED  = 25;
   localparam int N_RANDOM    = 370;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             kind;
      logic             last;
   } key_event_type;

   // typed = 1: the events are read straight off mask and kind
   typedef struct packed {
      logic [ROW_W-1:0]    row;
      logic [SAMPLE_W-1:0] sample;
      logic                typed;
      logic [SAMPLE_W-1:0] mask;
      logic                kind;
   } dir_scan_type;

   localparam dir_scan_type DIRECTED [0:N_DIRECTED-1] = '{
      '{3'd0, 8'hFF, 1'b1, 8'h00, KIND_PRESS},
      '{3'd0, 8'hFF, 1'b1, 8'h00, KIND_PRESS},
      '{3'd0, 8'hFF, 1'b1, 8'hFF, KIND_PRESS},
      '{3'd7, 8'h00, 1'b1, 8'h00, KIND_PRESS},
      '{3'd7, 8'h81, 1'b1, 8'h00, KIND_PRESS},
      '{3'd7, 8'h81, 1'b1, 8'h00, KIND_PRESS},
      '{3'd7, 8'h81, 1'b1, 8'h81, KIND_PRESS},
      '{3'd0, 8'h00, 1'b1, 8'h00, KIND_RELEASE},
      '{3'd0, 8'h00, 1'b1, 8'h00, KIND_RELEASE},
      '{3'd0, 8'h00, 1'b1, 8'hFF, KIND_RELEASE},
      '{3'd3, 8'h55, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'hAA, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'h55, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'h0F, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'h0F, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'h0F, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'hF0, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'hF0, 1'b0, 8'h00, KIND_PRESS},
      '{3'd3, 8'hF0, 1'b0, 8'h00, KIND_PRESS},
      '{3'd7, 8'h00, 1'b1, 8'h00, KIND_RELEASE},
      '{3'd7, 8'h00, 1'b1, 8'h00, KIND_RELEASE},
      '{3'd7, 8'h00, 1'b1, 8'h81, KIND_RELEASE},
      '{3'd1, 8'h01, 1'b1, 8'h00, KIND_PRESS},
      '{3'd1, 8'h01, 1'b1, 8'h00, KIND_PRESS},
      '{3'd1, 8'h01, 1'b1, 8'h01, KIND_PRESS}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ROW_W-1:0]    req_row_index = '0;
   logic [SAMPLE_W-1:0] req_column_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ROW_W-1:0]    rsp_event_row;
   logic [COL_W-1:0]    rsp_event_column;
   logic                rsp_event_kind;
   logic                rsp_last_event;

   logic [SAMPLE_W-1:0] scan_history [ROWS][DEPTH];
   logic [SAMPLE_W-1:0] key_level [ROWS];
   key_event_type       expected_events [$];
   int                  failures = 0;
   int                  cycles = 0;
   int                  burst_left = 0;
   int                  stall_phase_left = 0;
   int                  stall_mode = 0;

   key_matrix_debounce_events #(
      .ROW_COUNT     (ROWS),
      .HISTORY_DEPTH (DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_row_index     (req_row_index),
      .req_column_sample (req_column_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_row     (rsp_event_row),
      .rsp_event_column  (rsp_event_column),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_last_event    (rsp_last_event)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one event per set bit of mask, kind taken from the new level of that key
   task automatic queue_key_events(input logic [ROW_W-1:0] row, input logic [SAMPLE_W-1:0] mask,
                                   input logic [SAMPLE_W-1:0] new_level);
      key_event_type ev;
      for (int c = 0; c < COLUMN_COUNT; c++) begin
         if (mask[c]) begin
            ev.row    = row;
            ev.column = c[COL_W-1:0];
            ev.kind   = new_level[c] ? KIND_PRESS : KIND_RELEASE;
            ev.last   = ((mask >> (c + 1)) == '0);
            expected_events.push_back(ev);
         end
      end
   endtask

   task automatic debounce_scan(input logic [ROW_W-1:0] row, input logic [SAMPLE_W-1:0] sample,
                                input bit queue_events);
      logic [SAMPLE_W-1:0] all_high;
      logic [SAMPLE_W-1:0] all_low;
      logic [SAMPLE_W-1:0] was;
      logic [SAMPLE_W-1:0] now;
      all_high = '1;
      all_low  = '1;
      if (int'(row) >= ROWS) return;
      for (int d = DEPTH - 1; d > 0; d--) scan_history[row][d] = scan_history[row][d-1];
      scan_history[row][0] = sample;
      for (int d = 0; d < DEPTH; d++) begin
         all_high &= scan_history[row][d];
         all_low  &= ~scan_history[row][d];
      end
      was = key_level[row];
      now = (was | all_high) & ~all_low;
      key_level[row] = now;
      if (queue_events) queue_key_events(row, was ^ now, now);
   endtask

   // bursts of back-to-back scans with idle gaps in between
   task automatic send_scan(input logic [ROW_W-1:0] row, input logic [SAMPLE_W-1:0] sample,
                            input bit typed, input logic [SAMPLE_W-1:0] mask, input logic kind);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_row_index     <= row;
      req_column_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      debounce_scan(row, sample, !typed);
      if (typed) queue_key_events(row, mask, (kind == KIND_PRESS) ? 8'hFF : 8'h00);
   endtask

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         failures++;
      end
   endtask

   // receiver stall pattern: phases of no stall, heavy, light and long stalls
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_phase_left <= $urandom_range(40, 120);
         stall_mode       <= $urandom_range(0, 3);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_stall <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_stall <= (stall_phase_left % 16) < 11;
         end
      endcase
   end

   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event transaction, actual row %0d col %0d kind %0d last %0d",
                     $time, rsp_event_row, rsp_event_column, rsp_event_kind, rsp_last_event);
            failures++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_row", want.row, rsp_event_row);
            check_field("event_column", want.column, rsp_event_column);
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("last_event", want.last, rsp_last_event);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d events still expected", $time, expected_events.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int                  sent;
      int                  run_len;
      int                  mode;
      logic [ROW_W-1:0]    row;
      logic [SAMPLE_W-1:0] pattern;
      logic [SAMPLE_W-1:0] sample;
      sent = 0;
      for (int r = 0; r < ROWS; r++) begin
         key_level[r] = '0;
         for (int d = 0; d < DEPTH; d++) scan_history[r][d] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_scan(DIRECTED[i].row, DIRECTED[i].sample, DIRECTED[i].typed,
                   DIRECTED[i].mask, DIRECTED[i].kind);
      end

      while (sent < N_RANDOM) begin
         row  = ROW_W'($urandom_range(0, ROWS - 1));
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            // steady key pattern held long enough to debounce, with the odd bounce
            case ($urandom_range(0, 3))
               0: pattern = 8'h00;
               1: pattern = 8'hFF;
               default: pattern = SAMPLE_W'($urandom_range(0, 255));
            endcase
            run_len = $urandom_range(3, 5);
            for (int k = 0; k < run_len; k++) begin
               sample = pattern;
               if ($urandom_range(0, 4) == 0) sample = sample ^ (8'h01 << $urandom_range(0, 7));
               send_scan(row, sample, 1'b0, 8'h00, KIND_PRESS);
               sent++;
            end
         end else begin
            run_len = $urandom_range(1, 4);
            for (int k = 0; k < run_len; k++) begin
               if (mode == 9) row = ROW_W'($urandom_range(0, ROWS - 1));
               send_scan(row, SAMPLE_W'($urandom_range(0, 255)), 1'b0, 8'h00, KIND_PRESS);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (expected_events.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_row_mem.sv
hw/rtl/kmd_event_out.sv
hw/rtl/key_matrix_debounce_events.sv
bench/tb_key_matrix_debounce_events.sv
